>>> src/fssh_pkg.sv
`default_nettype none

package fssh_pkg;

	localparam int OP_W        = 2;
	localparam int SYM_W       = 8;
	localparam int POS_W       = 8;
	localparam int TOTAL_W     = 9;
	localparam int OUT_COUNT_W = 32;
	localparam int TABLE_DEPTH = 256;

	localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [TOTAL_W-1:0] TOTAL_FULL = TOTAL_W'(TABLE_DEPTH);

endpackage

`default_nettype wire

>>> src/fssh_if.sv
`default_nettype none

interface fssh_req_if;
	import fssh_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [SYM_W-1:0]  symbol_in;
	logic [POS_W-1:0]  read_position;

	modport source (output valid, output op, output symbol_in, output read_position,
		input ready);
	modport sink (input valid, input op, input symbol_in, input read_position,
		output ready);
endinterface

interface fssh_rsp_if;
	import fssh_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [SYM_W-1:0]       entry_symbol;
	logic [OUT_COUNT_W-1:0] entry_count;
	logic [POS_W-1:0]       entry_position;
	logic [TOTAL_W-1:0]     distinct_total;
	logic                   entry_valid;
	logic                   was_new;

	modport source (output valid, output entry_symbol, output entry_count,
		output entry_position, output distinct_total, output entry_valid, output was_new,
		input ready);
	modport sink (input valid, input entry_symbol, input entry_count,
		input entry_position, input distinct_total, input entry_valid, input was_new,
		output ready);
endinterface

`default_nettype wire

>>> src/fssh_ram.sv
`default_nettype none

module fssh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		// Read data holds between reads, so a stalled consumer sees it unchanged.
		if (re) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> src/first_seen_symbol_histogram.sv
// First-seen symbol histogram: a symbol frequency table.
// Items arrive on the req channel (valid/ready): op selects add, read or clear,
// symbol_in is the byte to count, read_position the table position to read.
// Every item gives exactly one result on the rsp channel (valid/ready).
// Each distinct byte takes the next table position when first added; its count
// then increments on each add and saturates at 2^COUNT_BITS - 1. A read returns
// the entry at a position, with entry_valid low beyond the filled positions.
// A clear empties the table in one go.
// An item goes through these steps in order: the symbol-to-position memory is read, then the
// position-indexed entry memory, then the entry is written back and the result
// registered. ready rises again at the edge that registers the result, so the
// block takes no new item until the result of the last one is registered.
// The result register lets the next item in while a result waits; if the
// receiver still holds the previous result when a new one is due, the block
// waits in its last step. Reset empties the table and drops any pending result;
// the memories need no clearing, as only entries written since the last clear
// are ever read.
`default_nettype none

module first_seen_symbol_histogram #(
	parameter int COUNT_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	fssh_req_if.sink   req,
	fssh_rsp_if.source rsp
);
	import fssh_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOOK = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	localparam int ENTRY_W = SYM_W + COUNT_BITS;

	state_t                 state_q;
	logic [OP_W-1:0]        op_q;
	logic [SYM_W-1:0]       sym_q;
	logic [POS_W-1:0]       rpos_q;
	logic                   seen_q;
	logic [POS_W-1:0]       pos_q;
	logic [TABLE_DEPTH-1:0] seen_flags_q;
	logic [TOTAL_W-1:0]     distinct_q;

	logic                   res_valid_q;
	logic [SYM_W-1:0]       res_symbol_q;
	logic [OUT_COUNT_W-1:0] res_count_q;
	logic [POS_W-1:0]       res_position_q;
	logic [TOTAL_W-1:0]     res_total_q;
	logic                   res_entry_valid_q;
	logic                   res_was_new_q;

	logic                   accept;
	logic                   finish;
	logic [POS_W-1:0]       map_rd;
	logic [POS_W-1:0]       look_pos;
	logic [ENTRY_W-1:0]     ent_rd;
	logic [SYM_W-1:0]       ent_sym;
	logic [COUNT_BITS-1:0]  ent_cnt;
	logic [COUNT_BITS-1:0]  new_cnt;
	logic [COUNT_BITS-1:0]  sel_cnt;
	logic [OUT_COUNT_W-1:0] sel_cnt_out;
	logic                   is_add_new;
	logic                   ent_we;
	logic                   in_range;

	logic [SYM_W-1:0]       nxt_symbol;
	logic [OUT_COUNT_W-1:0] nxt_count;
	logic [POS_W-1:0]       nxt_position;
	logic [TOTAL_W-1:0]     nxt_total;
	logic                   nxt_entry_valid;
	logic                   nxt_was_new;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && (state_q == ST_IDLE);
	assign finish    = (state_q == ST_UPD) && (!res_valid_q || rsp.ready);

	// Symbol to position map, read at acceptance.
	fssh_ram #(
		.WIDTH(POS_W),
		.DEPTH(TABLE_DEPTH)
	) u_map (
		.clk    (clk),
		.we     (finish && is_add_new),
		.wr_addr(sym_q),
		.wr_data(pos_q),
		.re     (accept),
		.rd_addr(req.symbol_in),
		.rd_data(map_rd)
	);

	// A known symbol uses its stored position, a new one the next free slot.
	always_comb begin
		if (op_q == OP_ADD) begin
			look_pos = seen_q ? map_rd : distinct_q[POS_W-1:0];
		end else begin
			look_pos = rpos_q;
		end
	end

	// Position-indexed entries: symbol and count side by side.
	fssh_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_entry (
		.clk    (clk),
		.we     (ent_we),
		.wr_addr(pos_q),
		.wr_data({sym_q, new_cnt}),
		.re     (state_q == ST_LOOK),
		.rd_addr(look_pos),
		.rd_data(ent_rd)
	);

	assign ent_sym    = ent_rd[ENTRY_W-1:COUNT_BITS];
	assign ent_cnt    = ent_rd[COUNT_BITS-1:0];
	assign is_add_new = (op_q == OP_ADD) && !seen_q;
	assign ent_we     = finish && (op_q == OP_ADD);
	assign in_range   = {1'b0, pos_q} < distinct_q;

	always_comb begin
		if (!seen_q) begin
			new_cnt = COUNT_BITS'(1);
		end else if (&ent_cnt) begin
			new_cnt = ent_cnt;
		end else begin
			new_cnt = ent_cnt + COUNT_BITS'(1);
		end
	end

	assign sel_cnt = (op_q == OP_ADD) ? new_cnt : ent_cnt;

	generate
		if (COUNT_BITS > OUT_COUNT_W) begin : g_cnt_wide
			assign sel_cnt_out = (|sel_cnt[COUNT_BITS-1:OUT_COUNT_W]) ? '1
				: sel_cnt[OUT_COUNT_W-1:0];
		end else begin : g_cnt_narrow
			assign sel_cnt_out = OUT_COUNT_W'(sel_cnt);
		end
	endgenerate

	always_comb begin
		nxt_symbol      = '0;
		nxt_count       = '0;
		nxt_position    = '0;
		nxt_total       = distinct_q;
		nxt_entry_valid = 1'b0;
		nxt_was_new     = 1'b0;
		unique case (op_q)
			OP_ADD: begin
				nxt_symbol      = sym_q;
				nxt_count       = sel_cnt_out;
				nxt_position    = pos_q;
				nxt_entry_valid = 1'b1;
				nxt_was_new     = !seen_q;
				if (!seen_q && (distinct_q != TOTAL_FULL)) begin
					nxt_total = distinct_q + TOTAL_W'(1);
				end
			end
			OP_READ: begin
				nxt_position = pos_q;
				if (in_range) begin
					nxt_symbol      = ent_sym;
					nxt_count       = sel_cnt_out;
					nxt_entry_valid = 1'b1;
				end
			end
			OP_CLEAR: begin
				nxt_total = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			seen_flags_q <= '0;
			distinct_q   <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (finish) begin
				distinct_q <= nxt_total;
				if (op_q == OP_CLEAR) begin
					seen_flags_q <= '0;
				end else if (is_add_new) begin
					seen_flags_q[sym_q] <= 1'b1;
				end
			end

			if (finish) begin
				res_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.op;
			sym_q  <= req.symbol_in;
			rpos_q <= req.read_position;
			seen_q <= seen_flags_q[req.symbol_in];
		end
		if (state_q == ST_LOOK) begin
			pos_q <= look_pos;
		end
		if (finish) begin
			res_symbol_q      <= nxt_symbol;
			res_count_q       <= nxt_count;
			res_position_q    <= nxt_position;
			res_total_q       <= nxt_total;
			res_entry_valid_q <= nxt_entry_valid;
			res_was_new_q     <= nxt_was_new;
		end
	end

	assign rsp.valid          = res_valid_q;
	assign rsp.entry_symbol   = res_symbol_q;
	assign rsp.entry_count    = res_count_q;
	assign rsp.entry_position = res_position_q;
	assign rsp.distinct_total = res_total_q;
	assign rsp.entry_valid    = res_entry_valid_q;
	assign rsp.was_new        = res_was_new_q;

endmodule

`default_nettype wire
